>>> rtl/core/nnt_pkg.sv
`timescale 1ns / 1ps
package nnt_pkg;

  localparam int MAX_CITIES_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  // fixed widths of the register and result fields
  localparam int CFG_W = 6;
  localparam int OUT_W = 6;

  // initial running minimum: limit squared
  localparam int THR_W = 54;
  localparam logic [26:0] DIST_LIMIT = 27'h7ffffff;
  localparam logic [THR_W-1:0] DIST_THR = THR_W'(DIST_LIMIT) * THR_W'(DIST_LIMIT);

endpackage

>>> rtl/core/nearest_neighbor_tour.sv
// nearest_neighbor_tour: greedy nearest-neighbor tour over a loaded city set
//
// input channel (in_valid_i / in_stall_o): one city per transaction, loaded
// at the next free index. cities beyond MAX_CITIES are dropped.
// a transaction with last_city_i set loads its city and starts the tour;
// in_stall_o stays high until the last result is in the output register.
// output channel (out_valid_o / out_stall_i): one transaction per tour
// position, or a single start_error_o transaction when start_city is not
// below the city count. the output register holds while out_stall_i is high.
// for n cities the tour list is built first; then for each position one
// stream read of the tour list memory per candidate feeds the distance
// pipeline, and last the results go out, each read from the list memory first.
// start_city is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while idle, the block itself does not enforce this.
// reset clears the count, the start city and the output valid; the memories
// keep their contents and need no clearing.
`timescale 1ns / 1ps
module nearest_neighbor_tour #(
  parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
  parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nnt_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic                         last_city_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [nnt_pkg::OUT_W-1:0]    tour_position_o,
  output logic [nnt_pkg::OUT_W-1:0]    city_index_o,
  output logic                         tour_end_o,
  output logic                         start_error_o
);
  import nnt_pkg::*;

  localparam int IDX_W = $clog2(MAX_CITIES);
  localparam int CNT_W = $clog2(MAX_CITIES + 1);
  localparam int CMP_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;
  localparam int XY_W  = 2 * COORD_BITS;
  localparam int DW    = 2 * COORD_BITS + 1;
  localparam int MIN_W = (DW > THR_W) ? DW : THR_W;
  localparam int TAG_W = 2 * IDX_W + 1;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_BUILD = 10'b0000000010,
    ST_PREV  = 10'b0000000100,
    ST_SCAN  = 10'b0000001000,
    ST_DRAIN = 10'b0000010000,
    ST_SWAP1 = 10'b0000100000,
    ST_SWAP2 = 10'b0001000000,
    ST_E_RD  = 10'b0010000000,
    ST_E_LD  = 10'b0100000000,
    ST_ERR   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] start_q;
  logic [CNT_W-1:0] count_q, n_q, n_new;
  logic [IDX_W-1:0] i_q, j_q, p_q;
  logic [IDX_W-1:0] prev_city_q, head_q, old_i_q, best_city_q, best_j_q;
  logic [MIN_W-1:0] min_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic prev_ld_q;

  logic             s1_v_q, s1_last_q, s2_v_q, s2_last_q;
  logic [IDX_W-1:0] s1_j_q, s2_j_q, s2_city_q;

  logic             out_valid_q, out_end_q, out_err_q;
  logic [OUT_W-1:0] out_pos_q, out_city_q;

  logic in_acc, out_free, not_full;
  logic [CMP_W-1:0] start_ext, p_ext, city_ext;
  logic [IDX_W-1:0] start_idx;
  logic j_is_last, i_is_last, p_is_last, more_pos;

  logic             list_we, list_re, coord_we, coord_re;
  logic [IDX_W-1:0] list_waddr, list_wdata, list_raddr, list_rdata;
  logic [IDX_W-1:0] coord_waddr, coord_raddr;
  logic [XY_W-1:0]  coord_rdata;

  logic             d_valid;
  logic [TAG_W-1:0] d_tag;
  logic [DW-1:0]    d_dist;
  logic [IDX_W-1:0] d_j, d_city;
  logic             d_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign not_full   = (count_q < CNT_W'(MAX_CITIES));
  assign n_new      = count_q + CNT_W'(not_full);
  assign start_ext  = CMP_W'(start_q);
  assign start_idx  = start_ext[IDX_W-1:0];
  assign p_ext      = CMP_W'(p_q);
  assign city_ext   = CMP_W'(list_rdata);
  assign j_is_last  = (CNT_W'(j_q) == n_q - CNT_W'(1));
  assign i_is_last  = (CNT_W'(i_q) == n_q - CNT_W'(1));
  assign p_is_last  = (CNT_W'(p_q) == n_q - CNT_W'(1));
  // another swap position exists after this one
  assign more_pos   = (CNT_W'(i_q) + CNT_W'(2) < n_q);

  assign {d_j, d_city, d_last} = d_tag;

  always_comb begin
    state_d     = state_q;
    list_we     = 1'b0;
    list_waddr  = i_q;
    list_wdata  = i_q;
    list_re     = 1'b0;
    list_raddr  = j_q;
    coord_we    = 1'b0;
    coord_waddr = count_q[IDX_W-1:0];
    coord_re    = 1'b0;
    coord_raddr = list_rdata;
    if (s1_v_q) begin
      coord_re = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          coord_we = not_full;
          if (last_city_i) begin
            state_d = (start_ext >= CMP_W'(n_new)) ? ST_ERR : ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        // start city at the head, the others in index order behind it
        list_we = 1'b1;
        if (i_q == start_idx) begin
          list_waddr = '0;
        end else if (i_q < start_idx) begin
          list_waddr = i_q + IDX_W'(1);
        end
        if (i_is_last) begin
          state_d = (n_q > CNT_W'(2)) ? ST_PREV : ST_E_RD;
        end
      end
      ST_PREV: begin
        coord_re    = 1'b1;
        coord_raddr = prev_city_q;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        list_re = 1'b1;
        if (j_is_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (d_valid && d_last) begin
          state_d = ST_SWAP1;
        end
      end
      ST_SWAP1: begin
        list_we    = 1'b1;
        list_waddr = best_j_q;
        list_wdata = old_i_q;
        state_d    = ST_SWAP2;
      end
      ST_SWAP2: begin
        list_we    = 1'b1;
        list_wdata = best_city_q;
        state_d    = more_pos ? ST_PREV : ST_E_RD;
      end
      ST_E_RD: begin
        list_re    = 1'b1;
        list_raddr = p_q;
        state_d    = ST_E_LD;
      end
      ST_E_LD: begin
        if (out_free) begin
          state_d = p_is_last ? ST_IDLE : ST_E_RD;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= '0;
      count_q     <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      prev_ld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      prev_ld_q <= (state_q == ST_PREV);
      s1_v_q    <= (state_q == ST_SCAN);
      s2_v_q    <= s1_v_q;
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        count_q <= last_city_i ? '0 : n_new;
      end
      if ((state_q == ST_E_LD || state_q == ST_ERR) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_city_i) begin
      n_q <= n_new;
      i_q <= '0;
    end
    if (state_q == ST_BUILD) begin
      i_q         <= i_is_last ? IDX_W'(1) : i_q + IDX_W'(1);
      prev_city_q <= start_idx;
      head_q      <= start_idx;
      p_q         <= '0;
    end
    if (state_q == ST_PREV) begin
      j_q         <= i_q;
      min_q       <= MIN_W'(DIST_THR);
      best_j_q    <= '0;
      best_city_q <= head_q;
    end
    if (prev_ld_q) begin
      prev_x_q <= coord_rdata[XY_W-1:COORD_BITS];
      prev_y_q <= coord_rdata[COORD_BITS-1:0];
    end
    if (state_q == ST_SCAN) begin
      j_q       <= j_q + IDX_W'(1);
      s1_j_q    <= j_q;
      s1_last_q <= j_is_last;
    end
    s2_j_q    <= s1_j_q;
    s2_city_q <= list_rdata;
    s2_last_q <= s1_last_q;
    if (d_valid) begin
      if (d_j == i_q) begin
        old_i_q <= d_city;
      end
      if (MIN_W'(d_dist) < min_q) begin
        min_q       <= MIN_W'(d_dist);
        best_j_q    <= d_j;
        best_city_q <= d_city;
      end
    end
    if (state_q == ST_SWAP2) begin
      prev_city_q <= best_city_q;
      i_q         <= i_q + IDX_W'(1);
      p_q         <= '0;
      // no winner: the default swap moved entry i into the head slot
      if (best_j_q == '0) begin
        head_q <= old_i_q;
      end
    end
    if (state_q == ST_E_LD && out_free) begin
      p_q        <= p_q + IDX_W'(1);
      out_pos_q  <= p_ext[OUT_W-1:0];
      out_city_q <= city_ext[OUT_W-1:0];
      out_end_q  <= p_is_last;
      out_err_q  <= 1'b0;
    end
    if (state_q == ST_ERR && out_free) begin
      out_pos_q  <= '0;
      out_city_q <= '0;
      out_end_q  <= 1'b1;
      out_err_q  <= 1'b1;
    end
  end

  nnt_ram #(
    .WIDTH (XY_W),
    .DEPTH (MAX_CITIES)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (coord_we),
    .waddr_i (coord_waddr),
    .wdata_i ({coord_x_i, coord_y_i}),
    .re_i    (coord_re),
    .raddr_i (coord_raddr),
    .rdata_o (coord_rdata)
  );

  nnt_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_CITIES)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  nnt_dist #(
    .COORD_BITS (COORD_BITS),
    .TAG_W      (TAG_W)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_v_q),
    .tag_i   ({s2_j_q, s2_city_q, s2_last_q}),
    .a_x_i   (prev_x_q),
    .a_y_i   (prev_y_q),
    .b_x_i   (coord_rdata[XY_W-1:COORD_BITS]),
    .b_y_i   (coord_rdata[COORD_BITS-1:0]),
    .valid_o (d_valid),
    .tag_o   (d_tag),
    .dist_o  (d_dist)
  );

  assign out_valid_o     = out_valid_q;
  assign tour_position_o = out_pos_q;
  assign city_index_o    = out_city_q;
  assign tour_end_o      = out_end_q;
  assign start_error_o   = out_err_q;

endmodule

>>> rtl/core/nnt_ram.sv
`timescale 1ns / 1ps
module nnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/nnt_dist.sv
`timescale 1ns / 1ps
module nnt_dist #(
  parameter int COORD_BITS = 16,
  parameter int TAG_W      = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [TAG_W-1:0]             tag_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  output logic                         valid_o,
  output logic [TAG_W-1:0]             tag_o,
  output logic [2*COORD_BITS:0]        dist_o
);

  localparam int SQ_W = 2 * COORD_BITS;
  localparam int DW   = SQ_W + 1;

  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [COORD_BITS:0]        mag_x, mag_y;

  logic                  v1_q, v2_q, v3_q;
  logic [TAG_W-1:0]      tag1_q, tag2_q, tag3_q;
  logic [COORD_BITS-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]       sx_q, sy_q;
  logic [DW-1:0]         dist_q;

  assign diff_x = {a_x_i[COORD_BITS-1], a_x_i} - {b_x_i[COORD_BITS-1], b_x_i};
  assign diff_y = {a_y_i[COORD_BITS-1], a_y_i} - {b_y_i[COORD_BITS-1], b_y_i};
  // magnitude always fits in COORD_BITS
  assign mag_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
  assign mag_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q <= tag_i;
    dx_q   <= mag_x[COORD_BITS-1:0];
    dy_q   <= mag_y[COORD_BITS-1:0];
    tag2_q <= tag1_q;
    sx_q   <= SQ_W'(dx_q) * SQ_W'(dx_q);
    sy_q   <= SQ_W'(dy_q) * SQ_W'(dy_q);
    tag3_q <= tag2_q;
    dist_q <= DW'(sx_q) + DW'(sy_q);
  end

  assign valid_o = v3_q;
  assign tag_o   = tag3_q;
  assign dist_o  = dist_q;

endmodule

>>> rtl/core/nnt_checker.sv
`timescale 1ns / 1ps
module nnt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      last_city_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [nnt_pkg::OUT_W-1:0] tour_position_o,
  input logic [nnt_pkg::OUT_W-1:0] city_index_o,
  input logic                      tour_end_o,
  input logic                      start_error_o
);
  import nnt_pkg::*;

  // an error result stands alone
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_error_o |->
      tour_end_o && tour_position_o == '0 && city_index_o == '0)
    else $error("error result is not a lone zero result");

  // the closing city of a set keeps the input busy
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_city_i |=> in_stall_o)
    else $error("input taken right after the closing city");

  // no new city while a tour is still going out
  a_tour_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !tour_end_o |-> in_stall_o)
    else $error("input open in the middle of a tour");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(tour_position_o) && $stable(city_index_o))
    else $error("stalled result changed");

endmodule

bind nearest_neighbor_tour nnt_checker u_nnt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .last_city_i     (last_city_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .tour_position_o (tour_position_o),
  .city_index_o    (city_index_o),
  .tour_end_o      (tour_end_o),
  .start_error_o   (start_error_o)
);
